@@ src/avg_pkg.sv @@
// ----------------------------------------------------------------------------
// avg_pkg
// Shared types, constants and arithmetic helpers of the arc vertex generator.
// ----------------------------------------------------------------------------
package avg_pkg;

    localparam int ANGLE_W   = 16;
    localparam int SWEEP_W   = 17;
    localparam int SEG_W     = 6;
    localparam int COORD_W   = 16;
    localparam int RAD_W     = 15;
    localparam int CW        = 34;              // CORDIC datapath, Q2.30 plus guard
    localparam int PROD_W    = RAD_W + 1 + CW;
    localparam int ATAN_LEN  = 24;
    localparam int IT_W      = 5;               // indexes the arctangent table
    localparam int Q_DEPTH   = 2;
    localparam int QPTR_W    = 1;
    localparam int QCNT_W    = 2;

    localparam logic [1:0] KIND_CIRCLE = 2'd0;
    localparam logic [1:0] KIND_ARC    = 2'd1;
    localparam logic [1:0] KIND_SECTOR = 2'd2;
    localparam logic [1:0] KIND_ALIAS  = 2'd3;

    localparam logic signed [CW-1:0] CORDIC_GAIN  = CW'(652032874);
    localparam logic signed [31:0]   QUARTER_PI   = 32'sd843314856;
    localparam logic [SWEEP_W-1:0]   FULL_TURN    = SWEEP_W'(65536);

    // request handed from the front end to the vertex engine
    typedef struct packed {
        logic                       sector;
        logic signed [COORD_W-1:0]  cx;
        logic signed [COORD_W-1:0]  cy;
        logic [RAD_W-1:0]           radius;
        logic [ANGLE_W-1:0]         start;
        logic [SWEEP_W-1:0]         base;   // sweep / n
        logic [SEG_W-1:0]           rmd;    // sweep % n
        logic [SEG_W-1:0]           n;
    } t_req;

    typedef enum logic [1:0] {
        F_IDLE,
        F_DIV,
        F_PUSH
    } t_fstate;

    typedef enum logic [2:0] {
        B_IDLE,
        B_ANGLE,
        B_ROT,
        B_MULX,
        B_SUMY,
        B_EMIT
    } t_bstate;

    function automatic logic signed [CW-1:0] atan_q30(input logic [IT_W-1:0] idx);
        logic signed [CW-1:0] v;
        unique case (idx)
            5'd0:  v = CW'(32'h3243F6A8);
            5'd1:  v = CW'(32'h1DAC6705);
            5'd2:  v = CW'(32'h0FADBAFC);
            5'd3:  v = CW'(32'h07F56EA6);
            5'd4:  v = CW'(32'h03FEAB76);
            5'd5:  v = CW'(32'h01FFD55B);
            5'd6:  v = CW'(32'h00FFFAAA);
            5'd7:  v = CW'(32'h007FFF55);
            5'd8:  v = CW'(32'h003FFFEA);
            5'd9:  v = CW'(32'h001FFFFD);
            5'd10: v = CW'(32'h000FFFFF);
            5'd11: v = CW'(32'h0007FFFF);
            5'd12: v = CW'(32'h0003FFFF);
            5'd13: v = CW'(32'h0001FFFF);
            5'd14: v = CW'(32'h0000FFFF);
            5'd15: v = CW'(32'h00007FFF);
            5'd16: v = CW'(32'h00003FFF);
            5'd17: v = CW'(32'h00001FFF);
            5'd18: v = CW'(32'h00000FFF);
            5'd19: v = CW'(32'h000007FF);
            5'd20: v = CW'(32'h000003FF);
            5'd21: v = CW'(32'h000001FF);
            5'd22: v = CW'(32'h000000FF);
            5'd23: v = CW'(32'h0000007F);
            default: v = '0;
        endcase
        return v;
    endfunction

    // centre + round(radius*trig / 2^30), saturated to Q8.8
    function automatic logic signed [COORD_W-1:0] coord(
        input logic signed [COORD_W-1:0] centre,
        input logic signed [PROD_W-1:0]  prod
    );
        logic signed [PROD_W-1:0] rnd;
        logic signed [PROD_W-31:0] off;
        logic signed [PROD_W-29:0] sum;
        rnd = prod + PROD_W'(64'sd536870912);
        off = rnd[PROD_W-1:30];
        sum = (PROD_W-28)'(centre) + (PROD_W-28)'(off);
        if (sum > (PROD_W-28)'(32767))
            return 16'sh7FFF;
        else if (sum < -(PROD_W-28)'(32768))
            return 16'sh8000;
        else
            return sum[COORD_W-1:0];
    endfunction

endpackage

@@ src/avg_front.sv @@
// ----------------------------------------------------------------------------
// avg_front
// Accepts a shape request, normalises kind and segment count, and splits the
// sweep into whole step and remainder with a bit-serial divider.
// ----------------------------------------------------------------------------
module avg_front #(
    parameter int MAX_SEGMENTS = 62
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_valid,
    output logic                                  o_ready,
    input  logic [1:0]                            i_kind,
    input  logic signed [avg_pkg::COORD_W-1:0]    i_center_x,
    input  logic signed [avg_pkg::COORD_W-1:0]    i_center_y,
    input  logic [avg_pkg::RAD_W-1:0]             i_radius,
    input  logic [avg_pkg::ANGLE_W-1:0]           i_start_angle,
    input  logic [avg_pkg::SWEEP_W-1:0]           i_sweep_angle,
    input  logic [avg_pkg::SEG_W-1:0]             i_segments,
    output logic                                  o_push,
    output avg_pkg::t_req                         o_req,
    input  logic                                  i_full
);
    localparam logic [avg_pkg::SEG_W-1:0] MAXN = avg_pkg::SEG_W'(MAX_SEGMENTS);
    localparam int CNT_W = $clog2(avg_pkg::SWEEP_W);

    avg_pkg::t_fstate r_state, n_state;
    avg_pkg::t_req    r_req;
    logic [avg_pkg::SWEEP_W-1:0] r_dvd;
    logic [avg_pkg::SEG_W-1:0]   r_rem;
    logic [CNT_W-1:0]            r_cnt;

    logic                        acc;
    logic [1:0]                  kind_n;
    logic [avg_pkg::SEG_W-1:0]   seg_n;
    logic [avg_pkg::SEG_W:0]     trial;
    logic                        qbit;
    logic                        div_done;

    assign acc = i_valid && o_ready;

    always_comb begin
        kind_n = (i_kind == avg_pkg::KIND_ALIAS) ? avg_pkg::KIND_ARC : i_kind;
        if (i_segments == '0)
            seg_n = avg_pkg::SEG_W'(1);
        else if (i_segments > MAXN)
            seg_n = MAXN;
        else
            seg_n = i_segments;
    end

    assign trial    = {r_rem, r_dvd[avg_pkg::SWEEP_W-1]};
    assign qbit     = (trial >= {1'b0, r_req.n});
    assign div_done = (r_cnt == CNT_W'(avg_pkg::SWEEP_W - 1));

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            avg_pkg::F_IDLE: if (acc) n_state = avg_pkg::F_DIV;
            avg_pkg::F_DIV:  if (div_done) n_state = avg_pkg::F_PUSH;
            avg_pkg::F_PUSH: if (!i_full) n_state = avg_pkg::F_IDLE;
            default:         n_state = avg_pkg::F_IDLE;
        endcase
    end

    always_comb begin
        o_ready = (r_state == avg_pkg::F_IDLE);
        o_push  = (r_state == avg_pkg::F_PUSH) && !i_full;
        o_req   = r_req;
        o_req.base = r_dvd;
        o_req.rmd  = r_rem;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= avg_pkg::F_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_req.sector <= (kind_n == avg_pkg::KIND_SECTOR);
            r_req.cx     <= i_center_x;
            r_req.cy     <= i_center_y;
            r_req.radius <= i_radius;
            r_req.n      <= seg_n;
            r_req.base   <= '0;
            r_req.rmd    <= '0;
            if (kind_n == avg_pkg::KIND_CIRCLE) begin
                r_req.start <= '0;
                r_dvd       <= avg_pkg::FULL_TURN;
            end else begin
                r_req.start <= i_start_angle;
                r_dvd       <= i_sweep_angle;
            end
            r_rem <= '0;
            r_cnt <= '0;
        end else if (r_state == avg_pkg::F_DIV) begin
            // restoring division, one quotient bit a cycle
            r_dvd <= {r_dvd[avg_pkg::SWEEP_W-2:0], qbit};
            r_rem <= qbit ? avg_pkg::SEG_W'(trial - {1'b0, r_req.n})
                          : trial[avg_pkg::SEG_W-1:0];
            r_cnt <= r_cnt + CNT_W'(1);
        end
    end

endmodule

@@ src/avg_fifo.sv @@
// ----------------------------------------------------------------------------
// avg_fifo
// Short request queue between the front end and the vertex engine.
// ----------------------------------------------------------------------------
module avg_fifo (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  avg_pkg::t_req i_req,
    output logic          o_full,
    input  logic          i_pop,
    output logic          o_empty,
    output avg_pkg::t_req o_req
);
    avg_pkg::t_req r_mem [avg_pkg::Q_DEPTH];
    logic [avg_pkg::QPTR_W-1:0] r_wp, r_rp;
    logic [avg_pkg::QCNT_W-1:0] r_cnt;

    assign o_full  = (r_cnt == avg_pkg::QCNT_W'(avg_pkg::Q_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_req   = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wp <= r_wp + avg_pkg::QPTR_W'(1);
            if (i_pop)  r_rp <= r_rp + avg_pkg::QPTR_W'(1);
            if (i_push && !i_pop)
                r_cnt <= r_cnt + avg_pkg::QCNT_W'(1);
            else if (i_pop && !i_push)
                r_cnt <= r_cnt - avg_pkg::QCNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wp] <= i_req;
    end

endmodule

@@ src/avg_back.sv @@
// ----------------------------------------------------------------------------
// avg_back
// Vertex engine: steps the point angle, runs an iterative CORDIC, scales by
// the radius and drives the registered vertex output.
// ----------------------------------------------------------------------------
module avg_back #(
    parameter int CORDIC_ITERATIONS = 16
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_empty,
    input  avg_pkg::t_req                        i_req,
    output logic                                 o_pop,
    output logic                                 o_valid,
    input  logic                                 i_ready,
    output logic signed [avg_pkg::COORD_W-1:0]   o_vertex_x,
    output logic signed [avg_pkg::COORD_W-1:0]   o_vertex_y,
    output logic                                 o_last
);
    localparam int CW = avg_pkg::CW;
    localparam int PW = avg_pkg::PROD_W;

    avg_pkg::t_bstate r_state, n_state;
    avg_pkg::t_req    r_req;

    logic [avg_pkg::SEG_W-1:0]    r_i;
    logic [avg_pkg::SWEEP_W-1:0]  r_off;
    logic [avg_pkg::SEG_W-1:0]    r_rem;
    logic [1:0]                   r_q;
    logic signed [CW-1:0]         r_x, r_y, r_z;
    logic [avg_pkg::IT_W-1:0]     r_it;
    logic signed [PW-1:0]         r_prod;
    logic signed [avg_pkg::COORD_W-1:0] r_px, r_py;
    logic                         r_plast, r_centre;

    logic                         r_out_valid, r_last;
    logic signed [avg_pkg::COORD_W-1:0] r_vx, r_vy;

    // control
    logic                         load, out_free, emit, rot_done, pt_last;

    // angle datapath
    logic [avg_pkg::ANGLE_W-1:0]  ang, ang_bias;
    logic [1:0]                   quad;
    logic signed [avg_pkg::ANGLE_W-1:0] resid;
    logic signed [47:0]           zprod;
    logic [avg_pkg::SEG_W:0]      rsum;
    logic                         carry;

    logic signed [CW-1:0]         dx, dy, at, cval, sval, mop;

    // ------------------------------------------------------------ next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            avg_pkg::B_IDLE:  if (!i_empty)
                                  n_state = i_req.sector ? avg_pkg::B_EMIT : avg_pkg::B_ANGLE;
            avg_pkg::B_ANGLE: n_state = avg_pkg::B_ROT;
            avg_pkg::B_ROT:   if (rot_done) n_state = avg_pkg::B_MULX;
            avg_pkg::B_MULX:  n_state = avg_pkg::B_SUMY;
            avg_pkg::B_SUMY:  n_state = avg_pkg::B_EMIT;
            avg_pkg::B_EMIT:  if (out_free)
                                  n_state = (r_plast && !r_centre) ? avg_pkg::B_IDLE
                                                                   : avg_pkg::B_ANGLE;
            default:          n_state = avg_pkg::B_IDLE;
        endcase
    end

    // ------------------------------------------------------------ control outputs
    always_comb begin
        out_free = !r_out_valid || i_ready;
        load     = (r_state == avg_pkg::B_IDLE) && !i_empty;
        emit     = (r_state == avg_pkg::B_EMIT) && out_free;
        rot_done = (r_it == avg_pkg::IT_W'(CORDIC_ITERATIONS - 1));
        pt_last  = (r_i == r_req.n);
        o_pop    = load;
    end

    // ------------------------------------------------------------ datapath
    always_comb begin
        ang      = r_req.start + r_off[avg_pkg::ANGLE_W-1:0];
        ang_bias = ang + avg_pkg::ANGLE_W'(8192);
        quad     = ang_bias[15:14];
        resid    = ang - {quad, 14'd0};
        zprod    = 48'(resid) * 48'(avg_pkg::QUARTER_PI);

        rsum  = {1'b0, r_rem} + {1'b0, r_req.rmd};
        carry = (rsum >= {1'b0, r_req.n});

        dx = r_y >>> r_it;
        dy = r_x >>> r_it;
        at = avg_pkg::atan_q30(r_it);

        unique case (r_q)
            2'd1:    begin cval = -r_y; sval =  r_x; end
            2'd2:    begin cval = -r_x; sval = -r_y; end
            2'd3:    begin cval =  r_y; sval = -r_x; end
            default: begin cval =  r_x; sval =  r_y; end
        endcase
        mop = (r_state == avg_pkg::B_MULX) ? cval : sval;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= avg_pkg::B_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (emit)
                r_out_valid <= 1'b1;
            else if (i_ready)
                r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            avg_pkg::B_IDLE: begin
                if (load) begin
                    r_req    <= i_req;
                    r_i      <= '0;
                    r_off    <= '0;
                    r_rem    <= '0;
                    r_px     <= i_req.cx;
                    r_py     <= i_req.cy;
                    r_plast  <= 1'b0;
                    r_centre <= i_req.sector;
                end
            end
            avg_pkg::B_ANGLE: begin
                r_q      <= quad;
                r_z      <= zprod[CW+12:13];
                r_x      <= avg_pkg::CORDIC_GAIN;
                r_y      <= '0;
                r_it     <= '0;
                r_centre <= 1'b0;
            end
            avg_pkg::B_ROT: begin
                if (!r_z[CW-1]) begin
                    r_x <= r_x - dx;
                    r_y <= r_y + dy;
                    r_z <= r_z - at;
                end else begin
                    r_x <= r_x + dx;
                    r_y <= r_y - dy;
                    r_z <= r_z + at;
                end
                r_it <= r_it + avg_pkg::IT_W'(1);
            end
            avg_pkg::B_MULX: begin
                r_prod <= PW'($signed({1'b0, r_req.radius})) * PW'(mop);
            end
            avg_pkg::B_SUMY: begin
                r_px    <= avg_pkg::coord(r_req.cx, r_prod);
                r_prod  <= PW'($signed({1'b0, r_req.radius})) * PW'(mop);
                r_plast <= pt_last;
            end
            avg_pkg::B_EMIT: begin
                // advance to the next point angle once this one is loaded into the output register
                if (emit && !r_centre) begin
                    r_i <= r_i + avg_pkg::SEG_W'(1);
                    r_off <= r_off + r_req.base + avg_pkg::SWEEP_W'(carry);
                    r_rem <= carry ? avg_pkg::SEG_W'(rsum - {1'b0, r_req.n})
                                   : rsum[avg_pkg::SEG_W-1:0];
                end
            end
            default: ;
        endcase
    end

    // y coordinate finishes on the way into the output register
    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_vx   <= r_px;
            r_vy   <= r_centre ? r_py : avg_pkg::coord(r_req.cy, r_prod);
            r_last <= r_plast && !r_centre;
        end
    end

    assign o_valid    = r_out_valid;
    assign o_vertex_x = r_vx;
    assign o_vertex_y = r_vy;
    assign o_last     = r_last;

endmodule

@@ src/arc_vertex_generator_core.sv @@
// ----------------------------------------------------------------------------
// arc_vertex_generator_core
// Tessellates circles, arcs and sectors into Q8.8 vertex streams.
// ----------------------------------------------------------------------------
// A request yields n+1 arc vertices (plus the centre first for a sector), the
// final one flagged by o_last. For each arc vertex the vertex engine performs
// one angle setup, the CORDIC rotations on a single shared shift-add unit,
// two radius multiplies on one multiplier and one output load; a sector
// centre goes straight to the output load. The front end accepts a request,
// runs a 17-step bit-serial sweep division and pushes the result, which
// overlaps the previous shape through a two-entry request queue.
// ----------------------------------------------------------------------------
module arc_vertex_generator_core #(
    parameter int MAX_SEGMENTS      = 62,
    parameter int CORDIC_ITERATIONS = 16
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_valid,
    output logic                                 o_ready,
    input  logic [1:0]                           i_kind,
    input  logic signed [avg_pkg::COORD_W-1:0]   i_center_x,
    input  logic signed [avg_pkg::COORD_W-1:0]   i_center_y,
    input  logic [avg_pkg::RAD_W-1:0]            i_radius,
    input  logic [avg_pkg::ANGLE_W-1:0]          i_start_angle,
    input  logic [avg_pkg::SWEEP_W-1:0]          i_sweep_angle,
    input  logic [avg_pkg::SEG_W-1:0]            i_segments,
    output logic                                 o_valid,
    input  logic                                 i_ready,
    output logic signed [avg_pkg::COORD_W-1:0]   o_vertex_x,
    output logic signed [avg_pkg::COORD_W-1:0]   o_vertex_y,
    output logic                                 o_last
);
    logic          push, full, pop, empty;
    avg_pkg::t_req wreq, rreq;

    avg_front #(
        .MAX_SEGMENTS (MAX_SEGMENTS)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_kind        (i_kind),
        .i_center_x    (i_center_x),
        .i_center_y    (i_center_y),
        .i_radius      (i_radius),
        .i_start_angle (i_start_angle),
        .i_sweep_angle (i_sweep_angle),
        .i_segments    (i_segments),
        .o_push        (push),
        .o_req         (wreq),
        .i_full        (full)
    );

    avg_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_req   (wreq),
        .o_full  (full),
        .i_pop   (pop),
        .o_empty (empty),
        .o_req   (rreq)
    );

    avg_back #(
        .CORDIC_ITERATIONS (CORDIC_ITERATIONS)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_empty    (empty),
        .i_req      (rreq),
        .o_pop      (pop),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .o_vertex_x (o_vertex_x),
        .o_vertex_y (o_vertex_y),
        .o_last     (o_last)
    );

endmodule

@@ test/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives shape requests into arc_vertex_generator_core, predicts every vertex
// with a local CORDIC model and checks the output stream in order.
// ----------------------------------------------------------------------------
module testbench;

    localparam int MAX_SEG  = 62;
    localparam int CORD_IT  = 16;
    localparam int CYC_LIMIT = 1500000;

    typedef struct {
        logic signed [15:0] vx;
        logic signed [15:0] vy;
        logic               last;
    } t_vertex;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                in_valid = 1'b0;
    logic                in_ready;
    logic [1:0]          kind = '0;
    logic signed [15:0]  cen_x = '0;
    logic signed [15:0]  cen_y = '0;
    logic [14:0]         radius = '0;
    logic [15:0]         start_ang = '0;
    logic [16:0]         sweep_ang = '0;
    logic [5:0]          segments = 6'd1;
    logic                out_valid;
    logic                out_ready = 1'b0;
    logic signed [15:0]  vert_x;
    logic signed [15:0]  vert_y;
    logic                vert_last;

    t_vertex  vertex_queue[$];
    int       errors = 0;
    int       cycles = 0;
    bit       no_idle = 1'b0;
    int       hold_off = 0;
    int       idle_left = 0;
    longint   atan_tab[24] = '{
        64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6, 64'h03FEAB76,
        64'h01FFD55B, 64'h00FFFAAA, 64'h007FFF55, 64'h003FFFEA, 64'h001FFFFD,
        64'h000FFFFF, 64'h0007FFFF, 64'h0003FFFF, 64'h0001FFFF, 64'h0000FFFF,
        64'h00007FFF, 64'h00003FFF, 64'h00001FFF, 64'h00000FFF, 64'h000007FF,
        64'h000003FF, 64'h000001FF, 64'h000000FF, 64'h0000007F};

    arc_vertex_generator_core dut (
        .i_clk(clk), .i_rst_n(rst_n), .i_valid(in_valid), .o_ready(in_ready),
        .i_kind(kind), .i_center_x(cen_x), .i_center_y(cen_y),
        .i_radius(radius), .i_start_angle(start_ang),
        .i_sweep_angle(sweep_ang), .i_segments(segments),
        .o_valid(out_valid), .i_ready(out_ready), .o_vertex_x(vert_x),
        .o_vertex_y(vert_y), .o_last(vert_last)
    );

    always begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // >>> on longint is arithmetic, i.e. floor
    function automatic void rotate(input logic [15:0] ang, output longint c,
                                   output longint s);
        logic [1:0]  quad;
        logic [15:0] resid;
        longint      x, y, z, dx, dy;
        quad  = 2'((32'(ang) + 8192) >> 14);
        resid = ang - 16'(quad) * 16'd16384;
        z = (longint'($signed(resid)) * 64'sd843314856) >>> 13;
        x = 652032874;
        y = 0;
        for (int i = 0; i < CORD_IT; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0) begin
                x -= dx; y += dy; z -= atan_tab[i];
            end else begin
                x += dx; y -= dy; z += atan_tab[i];
            end
        end
        case (quad)
            2'd1: begin c = -y; s = x; end
            2'd2: begin c = -x; s = -y; end
            2'd3: begin c = y; s = -x; end
            default: begin c = x; s = y; end
        endcase
    endfunction

    function automatic logic signed [15:0] place(input longint centre,
                                                 input longint rad, input longint t);
        longint v;
        v = centre + ((rad * t + (64'sd1 <<< 29)) >>> 30);
        if (v > 32767) v = 32767;
        if (v < -32768) v = -32768;
        return 16'(v);
    endfunction

    task automatic predict_vertices(input logic [1:0] k, input logic signed [15:0] cx,
                                    input logic signed [15:0] cy, input logic [14:0] r,
                                    input logic [15:0] st, input logic [16:0] sw,
                                    input logic [5:0] sg);
        int      n;
        longint  c, s, off;
        logic [15:0] a;
        logic [31:0] st_w, sw_w;
        t_vertex v;
        n = (sg == 0) ? 1 : (sg > MAX_SEG ? MAX_SEG : sg);
        st_w = st;
        sw_w = sw;
        if (k == avg_pkg::KIND_CIRCLE) begin
            st_w = 0;
            sw_w = 65536;
        end
        if (k == avg_pkg::KIND_SECTOR) begin
            v.vx = cx; v.vy = cy; v.last = 1'b0;
            vertex_queue.push_back(v);
        end
        for (int i = 0; i <= n; i++) begin
            off = (longint'(sw_w) * i) / n;
            a = 16'(longint'(st_w) + off);
            rotate(a, c, s);
            v.vx = place(cx, r, c);
            v.vy = place(cy, r, s);
            v.last = (i == n);
            vertex_queue.push_back(v);
        end
    endtask

    task automatic send_shape(input logic [1:0] k, input logic signed [15:0] cx,
                              input logic signed [15:0] cy, input logic [14:0] r,
                              input logic [15:0] st, input logic [16:0] sw,
                              input logic [5:0] sg);
        if (!no_idle && $urandom_range(0, 3) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge clk);
        end
        in_valid  <= 1'b1;
        kind      <= k;
        cen_x     <= cx;
        cen_y     <= cy;
        radius    <= r;
        start_ang <= st;
        sweep_ang <= sw;
        segments  <= sg;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        predict_vertices(k, cx, cy, r, st, sw, sg);
        @(negedge clk);
    endtask

    // receiver side: random stall bursts, or a long hold-off when requested
    always @(negedge clk) begin
        if (hold_off > 0) begin
            out_ready <= 1'b0;
            hold_off  <= hold_off - 1;
        end else if (idle_left > 0) begin
            out_ready <= 1'b0;
            idle_left <= idle_left - 1;
        end else if (!no_idle && $urandom_range(0, 4) == 0) begin
            out_ready <= 1'b0;
            idle_left <= $urandom_range(0, 5);
        end else begin
            out_ready <= 1'b1;
        end
    end

    always @(posedge clk) begin
        t_vertex e;
        cycles <= cycles + 1;
        if (rst_n && out_valid && out_ready) begin
            if (vertex_queue.size() == 0) begin
                $display("%0t: unexpected vertex x=%0d y=%0d last=%0b", $time,
                         vert_x, vert_y, vert_last);
                errors++;
            end else begin
                e = vertex_queue.pop_front();
                if (vert_x !== e.vx || vert_y !== e.vy || vert_last !== e.last) begin
                    $display("%0t: expected x=%0d y=%0d last=%0b, got x=%0d y=%0d last=%0b",
                             $time, e.vx, e.vy, e.last, vert_x, vert_y, vert_last);
                    errors++;
                end
            end
        end
    end

    always @(posedge clk) begin
        if (cycles > CYC_LIMIT) begin
            $display("arc_vertex_generator_core: mismatch");
            $finish;
        end
    end

    task automatic test_directed();
        send_shape(avg_pkg::KIND_CIRCLE, 16'sd0, 16'sd0, 15'd256, 16'd0, 17'd0, 6'd4);
        send_shape(avg_pkg::KIND_ARC, 16'sd100, -16'sd100, 15'd1000, 16'd8192, 17'd16384,
                   6'd3);
        send_shape(avg_pkg::KIND_SECTOR, -16'sd500, 16'sd700, 15'd2000, 16'd60000,
                   17'd30000, 6'd5);
        send_shape(avg_pkg::KIND_ALIAS, 16'sd5, 16'sd6, 15'd300, 16'd1000, 17'd5000, 6'd2);
        send_shape(avg_pkg::KIND_ARC, 16'sd0, 16'sd0, 15'd100, 16'd0, 17'd1000, 6'd0);
        send_shape(avg_pkg::KIND_ARC, 16'sd0, 16'sd0, 15'd100, 16'd0, 17'd65536, 6'd63);
        send_shape(avg_pkg::KIND_SECTOR, 16'sd1, 16'sd2, 15'd50, 16'd3, 17'd70000, 6'd62);
        send_shape(avg_pkg::KIND_ARC, 16'sd0, 16'sd0, 15'd100, 16'd100, 17'd131071, 6'd7);
        send_shape(avg_pkg::KIND_CIRCLE, 16'sd32767, -16'sd32768, 15'd32767, 16'hFFFF,
                   17'h1FFFF, 6'd8);
        send_shape(avg_pkg::KIND_SECTOR, -16'sd32768, 16'sd32767, 15'd32767, 16'd0,
                   17'd65536, 6'd6);
        send_shape(avg_pkg::KIND_ARC, 16'sd0, 16'sd0, 15'd0, 16'hFFFF, 17'd0, 6'd1);
        send_shape(avg_pkg::KIND_ARC, 16'sd0, 16'sd0, 15'h7FFF, 16'd24576, 17'd16384, 6'd2);
        send_shape(avg_pkg::KIND_SECTOR, 16'sd10, 16'sd10, 15'd400, 16'd40960, 17'd8192,
                   6'd1);
    endtask

    task automatic send_random();
        logic [5:0] sg;
        sg = ($urandom_range(0, 9) == 0) ? 6'($urandom_range(0, 63))
                                         : 6'($urandom_range(1, 8));
        send_shape(2'($urandom_range(0, 3)), 16'($urandom), 16'($urandom),
                   ($urandom_range(0, 3) == 0) ? 15'($urandom) : 15'($urandom_range(0, 4000)),
                   16'($urandom), 17'($urandom_range(0, 131071)), sg);
    endtask

    task automatic test_random(input int count);
        repeat (count) send_random();
    endtask

    task automatic test_backpressure();
        hold_off = 3000;
        repeat (6) send_random();
    endtask

    task automatic test_streaming(input int count);
        no_idle = 1'b1;
        repeat (count) send_random();
    endtask

    initial begin
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        test_directed();
        test_random(200);
        test_backpressure();
        test_streaming(50);
        in_valid <= 1'b0;
        while (vertex_queue.size() != 0) @(posedge clk);
        repeat (200) @(posedge clk);
        if (errors == 0)
            $display("arc_vertex_generator_core: match");
        else
            $display("arc_vertex_generator_core: mismatch");
        $finish;
    end
endmodule

@@ arc_vertex_generator_core.f @@
src/avg_pkg.sv
src/avg_front.sv
src/avg_fifo.sv
src/avg_back.sv
src/arc_vertex_generator_core.sv
test/testbench.sv
